@@ rtl/core/cvpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cvpm_pkg
// Shared types and constants for the cell voltage pack monitor.
// ----------------------------------------------------------------------------
package cvpm_pkg;

  localparam int NUM_CELLS = 128;
  localparam int STEP_MS   = 100;

  localparam logic [24:0] TOTAL_SAT = 25'h1FF_FFFF;
  localparam logic [8:0]  DRAIN_SAT = 9'h1FF;

  // Pack voltage: floor((total + 50) / 100) via reciprocal multiply.
  // Inputs at or above DECI_SAT_IN give a quotient above 16 bits.
  localparam logic [25:0] DECI_ROUND  = 26'd50;
  localparam logic [25:0] DECI_SAT_IN = 26'd6553600;
  localparam logic [23:0] DECI_RECIP  = 24'd10737419;   // ceil(2^30 / 100)
  localparam int          DECI_SHIFT  = 30;

  typedef enum logic [2:0] {
    CFG_IRR_LOW  = 3'd0,
    CFG_IRR_HIGH = 3'd1,
    CFG_MIN_CELL = 3'd2,
    CFG_MAX_DIFF = 3'd3,
    CFG_TOL      = 3'd4,
    CFG_HOLD     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] irr_low;
    logic [15:0] irr_high;
    logic [15:0] min_cell;
    logic [15:0] max_diff;
    logic [9:0]  tol;
    logic [15:0] hold;
  } cfg_t;

  // Finished statistics of one scan.
  typedef struct packed {
    logic [15:0] min_mv;
    logic [15:0] max_mv;
    logic [24:0] total;
    logic [8:0]  drains;
  } scan_t;

endpackage

@@ rtl/core/cvpm_accum.sv @@
// ----------------------------------------------------------------------------
// cvpm_accum
// Input register, running min/max/total/drain registers and the scan register.
// ----------------------------------------------------------------------------
module cvpm_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        cell_mv,
  input  logic               drain_req,
  input  logic               scan_last,
  input  logic [9:0]         tol,
  input  logic               rpt_ready,
  output logic               scan_valid,
  output cvpm_pkg::scan_t    scan
);

  logic        in_v;
  logic [15:0] in_cell;
  logic        in_drain;
  logic        in_last;

  logic [15:0] run_min;
  logic [15:0] run_max;
  logic [24:0] run_total;
  logic [8:0]  run_drains;
  logic        first_pending;

  logic [15:0] run_min_next;
  logic [15:0] run_max_next;
  logic [24:0] run_total_next;
  logic [8:0]  run_drains_next;
  logic [25:0] sum;
  logic        s1_free;
  logic        s0_go;

  assign s1_free  = !scan_valid || rpt_ready;
  assign s0_go    = in_v && (!in_last || s1_free);
  assign in_stall = in_v && !s0_go;

  always_comb begin
    run_min_next = run_min;
    run_max_next = run_max;
    if (first_pending) begin
      run_min_next = in_cell;
      run_max_next = in_cell;
    end else begin
      if ({1'b0, in_cell} > ({1'b0, run_max} + 17'(tol))) begin
        run_max_next = in_cell;
      end
      if (({1'b0, in_cell} + 17'(tol)) < {1'b0, run_min}) begin
        run_min_next = in_cell;
      end
    end
    sum            = {1'b0, run_total} + 26'(in_cell);
    run_total_next = sum[25] ? cvpm_pkg::TOTAL_SAT : sum[24:0];
    run_drains_next = run_drains;
    if (in_drain && (run_drains != cvpm_pkg::DRAIN_SAT)) begin
      run_drains_next = run_drains + 9'd1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v <= 1'b1;
    end else if (s0_go) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cell  <= cell_mv;
      in_drain <= drain_req;
      in_last  <= scan_last;
    end
  end

  // running values, cleared at scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min       <= '0;
      run_max       <= '0;
      run_total     <= '0;
      run_drains    <= '0;
      first_pending <= 1'b1;
    end else if (s0_go) begin
      if (in_last) begin
        run_min       <= '0;
        run_max       <= '0;
        run_total     <= '0;
        run_drains    <= '0;
        first_pending <= 1'b1;
      end else begin
        run_min       <= run_min_next;
        run_max       <= run_max_next;
        run_total     <= run_total_next;
        run_drains    <= run_drains_next;
        first_pending <= 1'b0;
      end
    end
  end

  // scan register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (s0_go && in_last) begin
      scan_valid <= 1'b1;
    end else if (scan_valid && rpt_ready) begin
      scan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && in_last) begin
      scan.min_mv <= run_min_next;
      scan.max_mv <= run_max_next;
      scan.total  <= run_total_next;
      scan.drains <= run_drains_next;
    end
  end

endmodule

@@ rtl/core/cvpm_report.sv @@
// ----------------------------------------------------------------------------
// cvpm_report
// Scan results, fault hysteresis timers and the result register.
// ----------------------------------------------------------------------------
module cvpm_report (
  input  logic               clk,
  input  logic               rst,
  input  cvpm_pkg::cfg_t     cfg,
  input  logic               scan_valid,
  input  cvpm_pkg::scan_t    scan,
  output logic               rpt_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        min_mv,
  output logic [15:0]        max_mv,
  output logic [23:0]        total_mv,
  output logic [15:0]        average_mv,
  output logic [15:0]        pack_decivolts,
  output logic [8:0]         drain_count,
  output logic               irrational_fault,
  output logic               low_charge_fault,
  output logic               imbalance_fault
);

  // {fault, timer} after one scan step
  function automatic logic [16:0] debounce(input logic [15:0] t, input logic cond,
                                           input logic [15:0] lim, input logic f);
    logic [16:0] up;
    logic [16:0] res;
    up = {1'b0, t} + 17'(cvpm_pkg::STEP_MS);
    if (cond) begin
      if (up >= {1'b0, lim}) res = {1'b1, lim};
      else                   res = {f, up[15:0]};
    end else begin
      if (t <= 16'(cvpm_pkg::STEP_MS)) res = 17'd0;
      else                             res = {f, t - 16'(cvpm_pkg::STEP_MS)};
    end
    return res;
  endfunction

  logic [15:0] irr_timer;
  logic [15:0] low_timer;
  logic [15:0] diff_timer;
  logic [2:0]  fault_bits;

  logic        take;
  logic [15:0] diff;
  logic        irr_cond;
  logic        low_cond;
  logic        diff_cond;
  logic [16:0] irr_next;
  logic [16:0] low_next;
  logic [16:0] diff_next;
  logic [24:0] avg_full;
  logic [15:0] avg;
  logic [25:0] deci_in;
  logic [46:0] deci_prod;
  logic [15:0] deci;
  logic [23:0] total_sat;

  assign rpt_ready = !out_valid || !out_stall;
  assign take      = scan_valid && rpt_ready;

  always_comb begin
    diff      = (scan.max_mv >= scan.min_mv) ? (scan.max_mv - scan.min_mv) : 16'd0;
    irr_cond  = (scan.min_mv < cfg.irr_low) || (scan.max_mv > cfg.irr_high);
    low_cond  = scan.min_mv < cfg.min_cell;
    diff_cond = ({1'b0, diff} + 17'(cfg.tol)) > {1'b0, cfg.max_diff};
    irr_next  = debounce(irr_timer,  irr_cond,  cfg.hold, fault_bits[0]);
    low_next  = debounce(low_timer,  low_cond,  cfg.hold, fault_bits[1]);
    diff_next = debounce(diff_timer, diff_cond, cfg.hold, fault_bits[2]);

    avg_full = scan.total / 25'(cvpm_pkg::NUM_CELLS);
    avg      = (avg_full > 25'hFFFF) ? 16'hFFFF : avg_full[15:0];

    deci_in   = {1'b0, scan.total} + cvpm_pkg::DECI_ROUND;
    deci_prod = 47'(deci_in[22:0]) * 47'(cvpm_pkg::DECI_RECIP);
    if (deci_in >= cvpm_pkg::DECI_SAT_IN) deci = 16'hFFFF;
    else deci = deci_prod[cvpm_pkg::DECI_SHIFT +: 16];

    total_sat = scan.total[24] ? 24'hFF_FFFF : scan.total[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irr_timer  <= '0;
      low_timer  <= '0;
      diff_timer <= '0;
      fault_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        irr_timer  <= irr_next[15:0];
        low_timer  <= low_next[15:0];
        diff_timer <= diff_next[15:0];
        fault_bits <= {diff_next[16], low_next[16], irr_next[16]};
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      min_mv           <= scan.min_mv;
      max_mv           <= scan.max_mv;
      total_mv         <= total_sat;
      average_mv       <= avg;
      pack_decivolts   <= deci;
      drain_count      <= scan.drains;
      irrational_fault <= irr_next[16];
      low_charge_fault <= low_next[16];
      imbalance_fault  <= diff_next[16];
    end
  end

endmodule

@@ rtl/core/cell_voltage_pack_monitor.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_pack_monitor
// Per-scan cell voltage statistics with debounced fault flags.
// ----------------------------------------------------------------------------
// Throughput: one cell item per cycle with no gaps between scans; only the
//   last cell of a scan stalls, while the scan register is full and blocked.
// Result path: input register, then scan register, then result register.
// Reset (rst, synchronous): running values cleared, timers and faults zero,
//   configuration registers back to their defaults, no result pending.
// ----------------------------------------------------------------------------
module cell_voltage_pack_monitor (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // cell item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] cell_mv,
  input  logic        drain_req,
  input  logic        scan_last,
  // scan result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] min_mv,
  output logic [15:0] max_mv,
  output logic [23:0] total_mv,
  output logic [15:0] average_mv,
  output logic [15:0] pack_decivolts,
  output logic [8:0]  drain_count,
  output logic        irrational_fault,
  output logic        low_charge_fault,
  output logic        imbalance_fault
);

  cvpm_pkg::cfg_t  cfg;
  cvpm_pkg::scan_t scan;
  logic            scan_valid;
  logic            rpt_ready;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.irr_low  <= 16'd1000;
      cfg.irr_high <= 16'd5000;
      cfg.min_cell <= 16'd2800;
      cfg.max_diff <= 16'd500;
      cfg.tol      <= 10'd1;
      cfg.hold     <= 16'd500;
    end else if (cfg_we) begin
      case (cvpm_pkg::cfg_idx_t'(cfg_index))
        cvpm_pkg::CFG_IRR_LOW:  cfg.irr_low  <= cfg_data;
        cvpm_pkg::CFG_IRR_HIGH: cfg.irr_high <= cfg_data;
        cvpm_pkg::CFG_MIN_CELL: cfg.min_cell <= cfg_data;
        cvpm_pkg::CFG_MAX_DIFF: cfg.max_diff <= cfg_data;
        cvpm_pkg::CFG_TOL:      cfg.tol      <= cfg_data[9:0];
        cvpm_pkg::CFG_HOLD:     cfg.hold     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: cell items fold into the running min/max/total/drain count.
  // The last cell of a scan hands the final figures to the scan register
  // and clears the running values, so the next scan starts on the next cycle.
  cvpm_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_mv    (cell_mv),
    .drain_req  (drain_req),
    .scan_last  (scan_last),
    .tol        (cfg.tol),
    .rpt_ready  (rpt_ready),
    .scan_valid (scan_valid),
    .scan       (scan)
  );

  // Stage 2: average (shift), pack voltage (reciprocal multiply), fault
  // conditions and the three hysteresis timers; results land in the output
  // register, which frees as soon as the consumer takes the item.
  cvpm_report u_report (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .scan_valid       (scan_valid),
    .scan             (scan),
    .rpt_ready        (rpt_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .min_mv           (min_mv),
    .max_mv           (max_mv),
    .total_mv         (total_mv),
    .average_mv       (average_mv),
    .pack_decivolts   (pack_decivolts),
    .drain_count      (drain_count),
    .irrational_fault (irrational_fault),
    .low_charge_fault (low_charge_fault),
    .imbalance_fault  (imbalance_fault)
  );

endmodule

@@ dv/tb_cell_voltage_pack_monitor.sv @@
// ----------------------------------------------------------------------------
// tb_cell_voltage_pack_monitor
// Self-checking bench for the cell voltage pack monitor: scan statistics
// and debounced fault flags, checked against an in-bench predictor.
// ----------------------------------------------------------------------------
// Cells go in on a valid/stall channel; every cell with scan_last set must
// give exactly one scan result, compared field by field in order. The run
// starts with hand-picked scans (extremes, tolerance band, limit moves,
// accumulator saturation), then random scans under several register
// settings and three idling patterns, plus one long result hold-off.
// ----------------------------------------------------------------------------
module tb_cell_voltage_pack_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_CYCLES    = 8;     // settle time after the last result
  localparam int END_SLACK       = 20;
  localparam int STALL_LIMIT     = 4000;  // cycles with nothing accepted
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BURST_SCANS     = 40;
  localparam int MAX_REPORTS     = 10;

  // Fault bit positions in the predicted fault vector
  localparam int FAULT_IRR = 0;
  localparam int FAULT_LOW = 1;
  localparam int FAULT_IMB = 2;

  localparam cvpm_pkg::cfg_t DEFAULT_REGS = '{irr_low: 16'd1000, irr_high: 16'd5000,
                                              min_cell: 16'd2800, max_diff: 16'd500,
                                              tol: 10'd1, hold: 16'd500};
  // Only a spread above 64512 mV can raise imbalance; the rest only decay
  localparam cvpm_pkg::cfg_t LOOSE_REGS = '{irr_low: 16'd0, irr_high: 16'hFFFF,
                                            min_cell: 16'd0, max_diff: 16'hFFFF,
                                            tol: 10'd1023, hold: 16'hFFFF};
  // Irrational trips every scan; low unless all 0xFFFF; imbalance unless flat
  localparam cvpm_pkg::cfg_t STRICT_REGS = '{irr_low: 16'hFFFF, irr_high: 16'd0,
                                             min_cell: 16'hFFFF, max_diff: 16'd0,
                                             tol: 10'd0, hold: 16'd100};

  typedef struct packed {
    logic [15:0] min_mv;
    logic [15:0] max_mv;
    logic [23:0] total_mv;
    logic [15:0] average_mv;
    logic [15:0] pack_decivolts;
    logic [8:0]  drain_count;
    logic        irrational;
    logic        low_charge;
    logic        imbalance;
  } scan_result_t;

  typedef enum int {
    STYLE_HEALTHY, STYLE_LOW, STYLE_IRRATIONAL, STYLE_SPREAD, STYLE_EDGE, STYLE_ANY
  } scan_style_t;

  // --------------------------------------------------------------------------
  // Scan predictor and result checker
  // --------------------------------------------------------------------------
  class pack_scan_checker;
    cvpm_pkg::cfg_t regs;
    logic [15:0]  run_min, run_max;
    logic [24:0]  run_total;
    logic [8:0]   run_drains;
    bit           first_cell;
    logic [15:0]  irr_timer, low_timer, diff_timer;
    logic [2:0]   faults;
    scan_result_t pending_scans[$];
    int unsigned  errors;

    function new();
      regs       = DEFAULT_REGS;
      run_min    = '0;
      run_max    = '0;
      run_total  = '0;
      run_drains = '0;
      first_cell = 1'b1;
      irr_timer  = '0;
      low_timer  = '0;
      diff_timer = '0;
      faults     = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return pending_scans.size();
    endfunction

    function void write_reg(cvpm_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        cvpm_pkg::CFG_IRR_LOW:  regs.irr_low  = val;
        cvpm_pkg::CFG_IRR_HIGH: regs.irr_high = val;
        cvpm_pkg::CFG_MIN_CELL: regs.min_cell = val;
        cvpm_pkg::CFG_MAX_DIFF: regs.max_diff = val;
        cvpm_pkg::CFG_TOL:      regs.tol      = val[9:0];
        cvpm_pkg::CFG_HOLD:     regs.hold     = val;
        default: ;
      endcase
    endfunction

    // One hysteresis step: up while the condition holds, down otherwise.
    function logic [15:0] step_timer(logic [15:0] t, bit cond, int unsigned b);
      int unsigned now_ms;
      int unsigned lim;
      now_ms = t;
      lim    = regs.hold;
      if (cond) begin
        if (now_ms + cvpm_pkg::STEP_MS >= lim) begin
          faults[b] = 1'b1;
          return regs.hold;
        end
        return 16'(now_ms + cvpm_pkg::STEP_MS);
      end
      if (now_ms <= cvpm_pkg::STEP_MS) begin
        faults[b] = 1'b0;
        return 16'd0;
      end
      return 16'(now_ms - cvpm_pkg::STEP_MS);
    endfunction

    function void take_cell(logic [15:0] sample, logic drain, logic last);
      int unsigned  c, tol, sum, avg, deci, diff;
      scan_result_t r;
      c   = sample;
      tol = regs.tol;
      if (first_cell) begin
        run_min    = sample;
        run_max    = sample;
        first_cell = 1'b0;
      end else begin
        if (c > run_max + tol) run_max = sample;
        if (c + tol < run_min) run_min = sample;
      end
      sum = run_total + c;
      if (sum > cvpm_pkg::TOTAL_SAT) sum = cvpm_pkg::TOTAL_SAT;
      run_total = sum[24:0];
      if (drain && run_drains != cvpm_pkg::DRAIN_SAT) run_drains = run_drains + 9'd1;
      if (!last) return;

      avg  = sum / cvpm_pkg::NUM_CELLS;
      deci = (sum + 50) / 100;
      diff = (run_max >= run_min) ? run_max - run_min : 0;
      irr_timer  = step_timer(irr_timer,
                              run_min < regs.irr_low || run_max > regs.irr_high, FAULT_IRR);
      low_timer  = step_timer(low_timer, run_min < regs.min_cell, FAULT_LOW);
      diff_timer = step_timer(diff_timer, diff + tol > regs.max_diff, FAULT_IMB);

      r.min_mv         = run_min;
      r.max_mv         = run_max;
      r.total_mv       = (sum > 32'hFF_FFFF) ? 24'hFF_FFFF : sum[23:0];
      r.average_mv     = (avg > 32'hFFFF) ? 16'hFFFF : avg[15:0];
      r.pack_decivolts = (deci > 32'hFFFF) ? 16'hFFFF : deci[15:0];
      r.drain_count    = run_drains;
      r.irrational     = faults[FAULT_IRR];
      r.low_charge     = faults[FAULT_LOW];
      r.imbalance      = faults[FAULT_IMB];
      pending_scans.push_back(r);

      run_min    = '0;
      run_max    = '0;
      run_total  = '0;
      run_drains = '0;
      first_cell = 1'b1;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t  MISMATCH %s", $time, msg);
    endfunction

    function void field_check(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) flag($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    function void check_scan(scan_result_t got);
      scan_result_t want;
      if (pending_scans.size() == 0) begin
        flag("scan result with no scan outstanding");
        return;
      end
      want = pending_scans.pop_front();
      field_check("min_mv",           want.min_mv,         got.min_mv);
      field_check("max_mv",           want.max_mv,         got.max_mv);
      field_check("total_mv",         want.total_mv,       got.total_mv);
      field_check("average_mv",       want.average_mv,     got.average_mv);
      field_check("pack_decivolts",   want.pack_decivolts, got.pack_decivolts);
      field_check("drain_count",      want.drain_count,    got.drain_count);
      field_check("irrational_fault", want.irrational,     got.irrational);
      field_check("low_charge_fault", want.low_charge,     got.low_charge);
      field_check("imbalance_fault",  want.imbalance,      got.imbalance);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; everything the bench drives starts at a known value
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = cvpm_pkg::CFG_IRR_LOW;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [15:0] cell_mv   = '0;
  logic        drain_req = 1'b0;
  logic        scan_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] min_mv;
  logic [15:0] max_mv;
  logic [23:0] total_mv;
  logic [15:0] average_mv;
  logic [15:0] pack_decivolts;
  logic [8:0]  drain_count;
  logic        irrational_fault;
  logic        low_charge_fault;
  logic        imbalance_fault;

  pack_scan_checker sb = new();

  // Idle percentages, changed by the stimulus between phases
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  bit          hold_off_req  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  cell_voltage_pack_monitor u_top (.*);

  // --------------------------------------------------------------------------
  // Monitors: sampled at the edge, so they see the pre-edge handshake values.
  // Input side feeds the predictor, output side is checked against it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_cell(cell_mv, drain_req, scan_last);
    if (!rst && out_valid && !out_stall)
      sb.check_scan({min_mv, max_mv, total_mv, average_mv, pack_decivolts, drain_count,
                     irrational_fault, low_charge_fault, imbalance_fault});
  end

  // Watchdog: any stretch with no handshake at all on either side is a hang.
  int unsigned dead_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles <= 0;
    end else if (dead_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t  watchdog: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // Result side stall. A hold-off request parks the sink for a long stretch
  // so results back up into the block and it has to stall its cell input.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one cell; returns in the time step of the edge that took it.
  // Valid only drops in the gap loop, never while an item is stalled.
  task automatic offer_cell(input logic [15:0] sample, input logic drain, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_mv   <= sample;
    drain_req <= drain;
    scan_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted scan has come out, plus
  // QUIET_CYCLES of quiet, so the pipeline is empty before any register write.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic drive_reg(input cvpm_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Only called with the block idle; all six registers every time.
  task automatic retune(input cvpm_pkg::cfg_t c);
    wait_results();
    drive_reg(cvpm_pkg::CFG_IRR_LOW,  c.irr_low);
    drive_reg(cvpm_pkg::CFG_IRR_HIGH, c.irr_high);
    drive_reg(cvpm_pkg::CFG_MIN_CELL, c.min_cell);
    drive_reg(cvpm_pkg::CFG_MAX_DIFF, c.max_diff);
    drive_reg(cvpm_pkg::CFG_TOL,      {6'd0, c.tol});
    drive_reg(cvpm_pkg::CFG_HOLD,     c.hold);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  // Thresholds in a plausible band so faults come and go.
  function automatic cvpm_pkg::cfg_t random_regs();
    cvpm_pkg::cfg_t c;
    c.irr_low  = 16'($urandom_range(1500, 500));
    c.irr_high = 16'($urandom_range(5500, 4300));
    c.min_cell = 16'($urandom_range(3300, 2500));
    c.max_diff = 16'($urandom_range(1000, 50));
    c.tol      = 10'($urandom_range(40, 0));
    c.hold     = 16'($urandom_range(8, 1) * 100 + $urandom_range(1) * $urandom_range(99));
    return c;
  endfunction

  // Mostly short scans; some single cells, full packs and oversize scans
  function automatic int unsigned pick_scan_len();
    int unsigned roll;
    roll = $urandom_range(199);
    if (roll < 3)  return $urandom_range(260, cvpm_pkg::NUM_CELLS + 1);
    if (roll < 10) return cvpm_pkg::NUM_CELLS;
    if (roll < 40) return 1;
    return $urandom_range(12, 2);
  endfunction

  function automatic logic [15:0] pick_cell(scan_style_t style);
    int unsigned which;
    case (style)
      STYLE_HEALTHY:    return 16'($urandom_range(3900, 3600));
      STYLE_LOW:        return 16'($urandom_range(3000, 2300));
      STYLE_IRRATIONAL: return $urandom_range(1) ? 16'($urandom_range(900, 0))
                                                 : 16'($urandom_range(65535, 5100));
      STYLE_SPREAD:     return 16'($urandom_range(4200, 2900));
      STYLE_EDGE: begin
        // hug one of the thresholds, off by up to two on either side
        which = $urandom_range(2);
        if (which == 0) return 16'(sb.regs.irr_low + $urandom_range(4) - 2);
        if (which == 1) return 16'(sb.regs.irr_high + $urandom_range(4) - 2);
        return 16'(sb.regs.min_cell + $urandom_range(4) - 2);
      end
      default:          return 16'($urandom);
    endcase
  endfunction

  // Scans come in runs of one style so fault timers can climb to the limit
  // and then decay again. Every scan is closed before the phase ends.
  task automatic random_phase(input cvpm_pkg::cfg_t c, input int unsigned n_cells);
    int unsigned sent;
    int unsigned len;
    int unsigned run_left;
    scan_style_t style;
    sent     = 0;
    run_left = 0;
    style    = STYLE_HEALTHY;
    retune(c);
    while (sent < n_cells) begin
      if (run_left == 0) begin
        style    = scan_style_t'($urandom_range(STYLE_ANY));
        run_left = $urandom_range(12, 2);
      end
      len = pick_scan_len();
      for (int k = 0; k < len; k++)
        offer_cell(pick_cell(style), 1'($urandom_range(1)), k == len - 1);
      sent     += len;
      run_left -= 1;
      if ($urandom_range(29) == 0) wait_results();  // sender pauses for drain-out
    end
  endtask

  // Park the sink, then keep pushing single-cell scans into the block.
  task automatic squeeze_results();
    hold_off_req = 1'b1;
    repeat (BURST_SCANS)
      offer_cell(16'($urandom_range(4000, 3000)), 1'($urandom_range(1)), 1'b1);
    wait_results();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cvpm_pkg::cfg_t r;
    int   k;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(28, 70);

    // Reset settings. Lone zero cell: first cell loads min and max.
    offer_cell(16'd0, 1'b1, 1'b1);
    // Field extremes inside one scan
    offer_cell(16'hFFFF, 1'b0, 1'b0);
    offer_cell(16'd0,    1'b1, 1'b0);
    offer_cell(16'h8000, 1'b0, 1'b1);
    // Tolerance band of 1: moves of one mV are ignored, two are taken
    offer_cell(16'd3000, 1'b1, 1'b0);
    offer_cell(16'd3001, 1'b0, 1'b0);
    offer_cell(16'd2999, 1'b1, 1'b0);
    offer_cell(16'd3002, 1'b0, 1'b0);
    offer_cell(16'd2997, 1'b1, 1'b1);
    // Build up the irrational timer below the reset limit
    offer_cell(16'd500, 1'b0, 1'b1);
    offer_cell(16'd500, 1'b0, 1'b1);

    // Limit dropped under a running timer: next rising step clamps and sets
    r      = DEFAULT_REGS;
    r.hold = 16'd200;
    r.tol  = 10'd0;
    retune(r);
    offer_cell(16'd500, 1'b1, 1'b1);
    // Zero tolerance: every single-mV move counts
    offer_cell(16'd3000, 1'b0, 1'b0);
    offer_cell(16'd3001, 1'b1, 1'b0);
    offer_cell(16'd2999, 1'b0, 1'b0);
    offer_cell(16'd3000, 1'b1, 1'b1);

    // Hold limit of zero: set on any bad scan, cleared on any good one.
    // Widest tolerance as well.
    r.hold = 16'd0;
    r.tol  = 10'd1023;
    retune(r);
    offer_cell(16'd500, 1'b0, 1'b1);
    offer_cell(16'd3700, 1'b0, 1'b1);
    offer_cell(16'd3000, 1'b1, 1'b0);
    offer_cell(16'd4000, 1'b0, 1'b0);
    offer_cell(16'd5000, 1'b1, 1'b0);
    offer_cell(16'd1900, 1'b0, 1'b1);

    // Accumulator saturation: total past 25 bits, drain count past 511
    retune(DEFAULT_REGS);
    for (k = 0; k < 520; k++) offer_cell(16'hFFFF, 1'b1, k == 519);

    // Random part: sender idles little, sink a lot
    random_phase(random_regs(), 115);
    random_phase(LOOSE_REGS, 105);

    // Sender idles a lot, sink little
    set_idling(70, 28);
    random_phase(random_regs(), 115);
    random_phase(STRICT_REGS, 105);

    // No idling on either side; long sink hold-off to back the block up
    set_idling(0, 0);
    squeeze_results();
    random_phase(random_regs(), 115);
    random_phase(random_regs(), 105);

    wait_results();
    repeat (END_SLACK) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
